>>> design/tdi_pkg.sv
// Shared constants, types and the length-code table of the time deinterleaver.
package tdi_pkg;

  localparam int CarriersModeOne = 96;
  localparam int LayerSegLimit   = 13;
  localparam int MiStep          = 5;
  localparam int MaxModeShift    = 2;
  localparam int DelayW          = 11;
  localparam int CfgDataW        = 4;

  typedef logic [4:0] ival_t;
  typedef logic [5:0] bound_t;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_SEGMENTS_A = 3'd1,
    REG_SEGMENTS_B = 3'd2,
    REG_SEGMENTS_C = 3'd3,
    REG_LENGTH_A   = 3'd4,
    REG_LENGTH_B   = 3'd5,
    REG_LENGTH_C   = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  localparam ival_t LEN_TABLE [3][8] = '{
    '{5'd0, 5'd4, 5'd8, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd2, 5'd4, 5'd8,  5'd0, 5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd1, 5'd2, 5'd4,  5'd0, 5'd0, 5'd0, 5'd0}
  };

  // effective setting: mode 1..3, cumulative segment bounds, I per layer
  typedef struct packed {
    logic [1:0] mode;
    bound_t     bound_a;
    bound_t     bound_b;
    bound_t     bound_c;
    ival_t      ival_a;
    ival_t      ival_b;
    ival_t      ival_c;
  } tdi_cfg_t;

  typedef struct packed {
    logic   busy;
    logic   restart;
  } tdi_clr_t;

endpackage

>>> design/tdi_ctrl.sv
// Configuration registers, effective setting and the memory clearing sweep.
module tdi_ctrl #(
  parameter int DELAY_WORDS = 948480,
  parameter int SLOTS       = 4992,
  parameter int CLR_W       = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  tdi_pkg::reg_idx_t         wr_idx,
  input  logic [tdi_pkg::CfgDataW-1:0] wr_data,
  output tdi_pkg::tdi_cfg_t         cfg,
  output tdi_pkg::tdi_clr_t         clr,
  output logic [CLR_W-1:0]          clr_addr
);
  import tdi_pkg::*;

  localparam int ClrLen = (DELAY_WORDS > SLOTS) ? DELAY_WORDS : SLOTS;

  logic [1:0] mode_r, mode_nxt;
  logic [3:0] seg_r [3];
  logic [3:0] seg_nxt [3];
  logic [2:0] len_r [3];
  logic [2:0] len_nxt [3];
  logic              busy_r;
  logic [CLR_W-1:0]  clr_addr_r;
  tdi_cfg_t          eff_nxt;

  function automatic tdi_cfg_t eff_of(logic [1:0] m_in, logic [3:0] sa, logic [3:0] sb,
                                      logic [3:0] sc, logic [2:0] la, logic [2:0] lb,
                                      logic [2:0] lc);
    tdi_cfg_t   e;
    logic [1:0] m;
    logic [3:0] a, b, c;
    m = (m_in == 2'd0) ? 2'd1 : m_in;
    a = (sa > 4'(LayerSegLimit)) ? 4'd0 : sa;
    b = (sb > 4'(LayerSegLimit)) ? 4'd0 : sb;
    c = (sc > 4'(LayerSegLimit)) ? 4'd0 : sc;
    e.mode    = m;
    e.bound_a = {2'b00, a};
    e.bound_b = {2'b00, a} + {2'b00, b};
    e.bound_c = {2'b00, a} + {2'b00, b} + {2'b00, c};
    e.ival_a  = LEN_TABLE[m - 2'd1][la];
    e.ival_b  = LEN_TABLE[m - 2'd1][lb];
    e.ival_c  = LEN_TABLE[m - 2'd1][lc];
    return e;
  endfunction

  always_comb begin
    mode_nxt = mode_r;
    seg_nxt  = seg_r;
    len_nxt  = len_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_MODE:       mode_nxt   = wr_data[1:0];
        REG_SEGMENTS_A: seg_nxt[0] = wr_data;
        REG_SEGMENTS_B: seg_nxt[1] = wr_data;
        REG_SEGMENTS_C: seg_nxt[2] = wr_data;
        REG_LENGTH_A:   len_nxt[0] = wr_data[2:0];
        REG_LENGTH_B:   len_nxt[1] = wr_data[2:0];
        REG_LENGTH_C:   len_nxt[2] = wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg     = eff_of(mode_r, seg_r[0], seg_r[1], seg_r[2], len_r[0], len_r[1], len_r[2]);
  assign eff_nxt = eff_of(mode_nxt, seg_nxt[0], seg_nxt[1], seg_nxt[2],
                          len_nxt[0], len_nxt[1], len_nxt[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 2'd1;
      seg_r      <= '{4'd13, 4'd0, 4'd0};
      len_r      <= '{3'd0, 3'd0, 3'd0};
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      seg_r  <= seg_nxt;
      len_r  <= len_nxt;
      if (eff_nxt != cfg) begin
        busy_r     <= 1'b1;
        clr_addr_r <= '0;
      end else if (busy_r) begin
        if (clr_addr_r == CLR_W'(ClrLen - 1)) begin
          busy_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  assign clr.busy    = busy_r;
  assign clr.restart = busy_r || (eff_nxt != cfg);
  assign clr_addr    = clr_addr_r;

endmodule

>>> design/tdi_front.sv
// Carrier counters: per-item line index, delay and line base address.
module tdi_front #(
  parameter int SEGMENT_COUNT = 13,
  parameter int DELAY_WORDS   = 948480,
  parameter int IDX_W         = 13,
  parameter int BASE_W        = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tdi_pkg::tdi_cfg_t       cfg,
  input  tdi_pkg::tdi_clr_t       clr,
  input  logic                    accept,
  output logic [IDX_W-1:0]        idx,
  output logic [tdi_pkg::DelayW-1:0] delay,
  output logic [BASE_W-1:0]       base,
  output logic                    use_line,
  output logic                    last
);
  import tdi_pkg::*;

  localparam int KW  = 9;
  localparam int SW  = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
  localparam int CW  = ((BASE_W > DelayW) ? BASE_W : DelayW) + 1;

  logic [IDX_W-1:0] idx_r;
  logic [KW-1:0]    k_r;
  logic [6:0]       mi_r, mi_step;
  logic [SW-1:0]    seg_r;
  logic [BASE_W-1:0] base_r;
  logic [KW-1:0]    k_last;
  ival_t            ival;
  logic [CW-1:0]    room;
  logic [11:0]      prod;

  assign k_last  = KW'((CarriersModeOne << (cfg.mode - 2'd1)) - 1);
  assign mi_step = (mi_r + 7'(MiStep) >= 7'(CarriersModeOne)) ?
                   mi_r + 7'(MiStep) - 7'(CarriersModeOne) : mi_r + 7'(MiStep);

  always_comb begin
    if (6'(seg_r) < cfg.bound_a)      ival = cfg.ival_a;
    else if (6'(seg_r) < cfg.bound_b) ival = cfg.ival_b;
    else if (6'(seg_r) < cfg.bound_c) ival = cfg.ival_c;
    else                              ival = '0;
  end

  assign prod     = 12'(ival) * 12'(7'(CarriersModeOne - 1) - mi_r);
  assign delay    = prod[DelayW-1:0];
  assign room     = CW'(DELAY_WORDS) - CW'(base_r);
  assign use_line = (delay != '0) && (CW'(delay) <= room);
  assign last     = (seg_r == SW'(SEGMENT_COUNT - 1)) && (k_r == k_last);
  assign idx      = idx_r;
  assign base     = base_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr.restart) begin
      idx_r  <= '0;
      k_r    <= '0;
      mi_r   <= '0;
      seg_r  <= '0;
      base_r <= '0;
    end else if (accept) begin
      if (last) begin
        idx_r  <= '0;
        k_r    <= '0;
        mi_r   <= '0;
        seg_r  <= '0;
        base_r <= '0;
      end else begin
        idx_r  <= idx_r + 1'b1;
        base_r <= use_line ? BASE_W'(CW'(base_r) + CW'(delay)) : base_r;
        if (k_r == k_last) begin
          k_r   <= '0;
          mi_r  <= '0;
          seg_r <= seg_r + 1'b1;
        end else begin
          k_r  <= k_r + 1'b1;
          mi_r <= mi_step;
        end
      end
    end
  end

endmodule

>>> design/tdi_line_mem.sv
// Ring pointer memory and delay memory with the read-modify-write pipeline.
module tdi_line_mem #(
  parameter int DELAY_WORDS = 948480,
  parameter int SLOTS       = 4992,
  parameter int WORD_W      = 32,
  parameter int IDX_W       = 13,
  parameter int BASE_W      = 20,
  parameter int ADDR_W      = 20,
  parameter int CLR_W       = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  tdi_pkg::tdi_clr_t          clr,
  input  logic [CLR_W-1:0]           clr_addr,
  input  logic                       acc,
  input  logic [WORD_W-1:0]          word,
  input  logic [IDX_W-1:0]           idx,
  input  logic [tdi_pkg::DelayW-1:0] delay,
  input  logic [BASE_W-1:0]          base,
  input  logic                       use_line,
  input  logic                       last,
  output logic                       res_valid,
  output logic [WORD_W-1:0]          res_word,
  output logic                       res_last
);
  import tdi_pkg::*;

  logic [DelayW-1:0] ring_mem [SLOTS];
  logic [WORD_W-1:0] dmem [DELAY_WORDS];

  logic              s1_valid_r, s1_use_r, s1_last_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [DelayW-1:0] s1_delay_r;
  logic [BASE_W-1:0] s1_base_r;
  logic [DelayW-1:0] ring_rd_r;
  logic              s2_valid_r, s2_use_r, s2_last_r;
  logic [WORD_W-1:0] s2_word_r, d_rd_r;

  logic [DelayW-1:0] pos, pos_inc;
  logic [ADDR_W-1:0] daddr;
  logic              line_op;
  logic              ring_we, d_we;
  logic [IDX_W-1:0]  ring_wa;
  logic [DelayW-1:0] ring_wd;
  logic [ADDR_W-1:0] d_wa;
  logic [WORD_W-1:0] d_wd;

  assign line_op = en && s1_valid_r && s1_use_r;
  assign pos     = (ring_rd_r >= s1_delay_r) ? '0 : ring_rd_r;
  assign pos_inc = (pos + 1'b1 == s1_delay_r) ? '0 : pos + 1'b1;
  assign daddr   = ADDR_W'(s1_base_r + BASE_W'(pos));

  always_comb begin
    if (clr.busy) begin
      ring_we = (CLR_W'(SLOTS) > clr_addr);
      ring_wa = IDX_W'(clr_addr);
      ring_wd = '0;
      d_we    = (CLR_W'(DELAY_WORDS) > clr_addr);
      d_wa    = ADDR_W'(clr_addr);
      d_wd    = '0;
    end else begin
      ring_we = line_op;
      ring_wa = s1_idx_r;
      ring_wd = pos_inc;
      d_we    = line_op;
      d_wa    = daddr;
      d_wd    = s1_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    if (en) ring_rd_r <= ring_mem[idx];
  end

  // read-first: a line read and its write back share one address
  always_ff @(posedge clk) begin
    if (d_we) dmem[d_wa] <= d_wd;
    if (line_op) d_rd_r <= dmem[daddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_word_r  <= word;
      s1_idx_r   <= idx;
      s1_delay_r <= delay;
      s1_base_r  <= base;
      s1_use_r   <= use_line;
      s1_last_r  <= last;
      s2_word_r  <= s1_word_r;
      s2_use_r   <= s1_use_r;
      s2_last_r  <= s1_last_r;
    end
  end

  assign res_valid = s2_valid_r;
  assign res_word  = s2_use_r ? d_rd_r : s2_word_r;
  assign res_last  = s2_last_r;

endmodule

>>> design/tdi_out_buf.sv
// Two-entry output buffer that decouples the pipeline from the result channel.
module tdi_out_buf #(
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] head,
  output logic [1:0]    count
);
  logic [DW-1:0] ent_r [2];
  logic [1:0]    cnt_r;
  logic          rd_r, wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_data;
  end

  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rd_r];
  assign count     = cnt_r;

endmodule

>>> design/isdbt_time_deinterleaver.sv
// Top level of the ISDB-T time deinterleaver: stream ports, control, pipeline, output buffer.
// From input accept, an item passes two registered stages (ring read, then delay memory
// read and write back) before its result enters the output buffer.
// Throughput: one item per clock while the output buffer has room, set by one read and one
// write of each memory per cycle. Reset (rst_n low, synchronous) and any write that changes
// the effective setting start a clearing pass over max(DELAY_WORDS, SEGMENT_COUNT*384)
// addresses (948480 by default) during which in_tready stays low; configuration writes are taken throughout.
module isdbt_time_deinterleaver #(
  parameter int SEGMENT_COUNT = 13,
  parameter int SAMPLE_WIDTH  = 16,
  parameter int DELAY_WORDS   = 948480
) (
  input  logic clk,
  input  logic rst_n,
  // {sample_q, sample_i}, sample_i in the low bits, zero padded to whole bytes
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,
  // {out_q, out_i}, out_i in the low bits, zero padded to whole bytes
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     out_tdata,
  output logic                                    out_tlast,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [2:0]                              cfg_index,
  input  logic [tdi_pkg::CfgDataW-1:0]            cfg_data
);
  import tdi_pkg::*;

  localparam int TdataW = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int WordW  = 2*SAMPLE_WIDTH;
  localparam int Slots  = SEGMENT_COUNT * (CarriersModeOne << MaxModeShift);
  localparam int IdxW   = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int BaseW  = $clog2(DELAY_WORDS + 1);
  localparam int AddrW  = (DELAY_WORDS > 1) ? $clog2(DELAY_WORDS) : 1;
  localparam int ClrLen = (DELAY_WORDS > Slots) ? DELAY_WORDS : Slots;
  localparam int ClrW   = $clog2(ClrLen + 1);

  tdi_cfg_t          cfg;
  tdi_clr_t          clr;
  logic [ClrW-1:0]   clr_addr;
  logic              en, accept;
  logic [IdxW-1:0]   idx;
  logic [DelayW-1:0] delay;
  logic [BaseW-1:0]  base;
  logic              use_line, last;
  logic              res_valid, res_last;
  logic [WordW-1:0]  res_word;
  logic [WordW:0]    head;
  logic [1:0]        buf_cnt;
  logic              pop;

  assign cfg_ready = 1'b1;

  tdi_ctrl #(
    .DELAY_WORDS(DELAY_WORDS), .SLOTS(Slots), .CLR_W(ClrW)
  ) u_ctrl (
    .clk, .rst_n,
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (reg_idx_t'(cfg_index)),
    .wr_data (cfg_data),
    .cfg, .clr, .clr_addr
  );

  // pipeline advances only while the output buffer can take what is in flight
  assign en        = (buf_cnt < 2'd2);
  assign in_tready = en && !clr.busy;
  assign accept    = in_tvalid && in_tready;

  tdi_front #(
    .SEGMENT_COUNT(SEGMENT_COUNT), .DELAY_WORDS(DELAY_WORDS), .IDX_W(IdxW), .BASE_W(BaseW)
  ) u_front (
    .clk, .rst_n, .cfg, .clr, .accept,
    .idx, .delay, .base, .use_line, .last
  );

  tdi_line_mem #(
    .DELAY_WORDS(DELAY_WORDS), .SLOTS(Slots), .WORD_W(WordW), .IDX_W(IdxW),
    .BASE_W(BaseW), .ADDR_W(AddrW), .CLR_W(ClrW)
  ) u_mem (
    .clk, .rst_n, .en, .clr, .clr_addr,
    .acc      (accept),
    .word     (in_tdata[WordW-1:0]),
    .idx, .delay, .base, .use_line, .last,
    .res_valid, .res_word, .res_last
  );

  assign pop = out_tvalid && out_tready;

  tdi_out_buf #(.DW(WordW + 1)) u_obuf (
    .clk, .rst_n,
    .push      (en && res_valid),
    .push_data ({res_last, res_word}),
    .pop,
    .not_empty (out_tvalid),
    .head,
    .count     (buf_cnt)
  );

  assign out_tdata = TdataW'(head[WordW-1:0]);
  assign out_tlast = head[WordW];

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.busy |-> !in_tready) else $error("item accepted during clearing pass");
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt <= 2'd2) else $error("output buffer overflow");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_cnt == 2'd2) |=> (buf_cnt != 2'd3)) else $error("push into full buffer");
  a_front_zero_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.busy |=> (idx == '0) || clr.busy == 1'b0)
    else $error("carrier count not restarted by clear");

endmodule

>>> verif/tb_isdbt_time_deinterleaver.sv
// Self-checking testbench for the ISDB-T time deinterleaver: stream stimulus, delay-line predictor.
module tb_isdbt_time_deinterleaver;
  timeunit 1ns;
  timeprecision 1ps;
  import tdi_pkg::*;

  localparam int NumSegments  = 13;
  localparam int DelayWords   = 948480;
  // no-progress limit: covers a full clearing pass after reset or a setting change, several times
  localparam int StallLimit   = 4_000_000;
  localparam int DrainCycles  = 20;

  typedef logic signed [15:0] sample_t;

  // one delayed carrier as seen on the result port
  typedef struct {
    sample_t s_i;
    sample_t s_q;
    logic    last;
  } carrier_out_t;

  // directed row: input sample, and an expected result where it is obvious
  typedef struct {
    sample_t s_i;
    sample_t s_q;
    bit      typed;
    sample_t e_i;
    sample_t e_q;
    logic    e_last;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  isdbt_time_deinterleaver dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: registers, effective setting, delay lines
  // ---------------------------------------------------------------------------
  logic [3:0]  reg_val [7];
  int unsigned eff_mode;
  int unsigned eff_seg [3];
  int unsigned eff_ival [3];
  logic [31:0] line_mem [int unsigned];   // absent entry reads as zero
  int unsigned ring_pos [int unsigned];
  int unsigned carrier_idx;
  int unsigned line_base;

  carrier_out_t pending_carriers [$];
  int           fail_count = 0;
  bit           quiet = 1'b0;       // no idling on either side

  // typed expectation travelling alongside the item being offered
  bit           cur_typed = 1'b0;
  carrier_out_t cur_expect;

  function automatic void clear_lines();
    line_mem.delete();
    ring_pos.delete();
    carrier_idx = 0;
    line_base = 0;
  endfunction

  // recompute effective setting; lines are rebuilt only when it actually changes
  function automatic void apply_setting();
    int unsigned m, s, l;
    bit changed;
    m = reg_val[REG_MODE] & 4'h3;
    if (m == 0) m = 1;   // mode zero behaves as mode 1
    changed = (m != eff_mode);
    eff_mode = m;
    for (int j = 0; j < 3; j++) begin
      s = reg_val[REG_SEGMENTS_A + j];
      if (s > LayerSegLimit) s = 0;
      l = LEN_TABLE[m-1][reg_val[REG_LENGTH_A + j] & 4'h7];
      if (s != eff_seg[j] || l != eff_ival[j]) changed = 1'b1;
      eff_seg[j] = s;
      eff_ival[j] = l;
    end
    if (changed) clear_lines();
  endfunction

  function automatic void reset_setting();
    foreach (reg_val[r]) reg_val[r] = '0;
    reg_val[REG_MODE] = 4'd1;
    reg_val[REG_SEGMENTS_A] = 4'd13;
    eff_mode = 0;
    apply_setting();
    clear_lines();
  endfunction

  // push one carrier through its delay line and return what comes out
  function automatic carrier_out_t deinterleave(sample_t s_i, sample_t s_q);
    carrier_out_t r;
    int unsigned cps, total, seg, k, mi, ival, dly, pos, addr;
    logic [31:0] word, res;
    cps = CarriersModeOne << (eff_mode - 1);
    total = NumSegments * cps;
    if (carrier_idx >= total) begin
      carrier_idx = 0;
      line_base = 0;
    end
    seg = carrier_idx / cps;
    k = carrier_idx % cps;
    mi = (MiStep * k) % CarriersModeOne;
    if (seg < eff_seg[0]) ival = eff_ival[0];
    else if (seg < eff_seg[0] + eff_seg[1]) ival = eff_ival[1];
    else if (seg < eff_seg[0] + eff_seg[1] + eff_seg[2]) ival = eff_ival[2];
    else ival = 0;   // uncovered carriers pass straight through
    dly = ival * (CarriersModeOne - 1 - mi);
    word = {s_q, s_i};
    res = word;
    if (dly != 0 && line_base <= DelayWords && dly <= DelayWords - line_base) begin
      pos = ring_pos.exists(carrier_idx) ? ring_pos[carrier_idx] : 0;
      if (pos >= dly) pos = 0;
      addr = line_base + pos;
      res = line_mem.exists(addr) ? line_mem[addr] : 32'h0;
      line_mem[addr] = word;
      pos++;
      if (pos == dly) pos = 0;
      ring_pos[carrier_idx] = pos & 11'h7FF;
      line_base += dly;
    end
    carrier_idx++;
    r.last = 1'b0;
    if (carrier_idx >= total) begin
      carrier_idx = 0;
      line_base = 0;
      r.last = 1'b1;
    end
    r.s_i = res[15:0];
    r.s_q = res[31:16];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted items / writes, check accepted results
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    carrier_out_t exp_c, pred;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_val[cfg_index] = cfg_data;
        apply_setting();
      end
      if (in_tvalid && in_tready) begin
        pred = deinterleave(in_tdata[15:0], in_tdata[31:16]);
        if (cur_typed) pred = cur_expect;
        pending_carriers.insert(pending_carriers.size(), pred);
      end
      if (out_tvalid && out_tready) begin
        if (pending_carriers.size() == 0) begin
          $error("result with nothing expected: tdata=%h tlast=%b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          exp_c = pending_carriers[0];
          pending_carriers.delete(0);
          if (out_tdata[15:0] !== exp_c.s_i) begin
            $error("out_i expected %0d got %0d", exp_c.s_i, $signed(out_tdata[15:0]));
            fail_count++;
          end
          if (out_tdata[31:16] !== exp_c.s_q) begin
            $error("out_q expected %0d got %0d", exp_c.s_q, $signed(out_tdata[31:16]));
            fail_count++;
          end
          if (out_tlast !== exp_c.last) begin
            $error("last_of_symbol expected %b got %b", exp_c.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    // watchdog: any handshake counts as progress
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side back-pressure: random bursts of low out_tready, with calm stretches between
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  always @(negedge clk) begin
    if (quiet) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_tready = 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(50, 300);
      out_tready = 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (called right after a rising edge; change inputs on the falling edge)
  // ---------------------------------------------------------------------------
  int unsigned send_calm = 0;

  task automatic send_carrier(sample_t s_i, sample_t s_q, bit typed, carrier_out_t e);
    int unsigned gap;
    if (!quiet && send_calm == 0 && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else if (send_calm == 0 && $urandom_range(0, 60) == 0) begin
      send_calm = $urandom_range(50, 300);
    end
    if (send_calm > 0) send_calm--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {s_q, s_i};
    cur_typed = typed;
    cur_expect = e;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid = 1'b0;
    cur_typed = 1'b0;
  endtask

  // registers change only once every expected result is out and the pipeline has drained
  task automatic write_reg(reg_idx_t idx, logic [3:0] val);
    wait (pending_carriers.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return sample_t'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic random_carriers(int unsigned n);
    carrier_out_t none;
    none = '{default: '0};
    for (int unsigned c = 0; c < n; c++)
      send_carrier(rand_sample(), rand_sample(), 1'b0, none);
    end_burst();
  endtask

  // after reset every I is zero, so each carrier comes straight back; last flag
  // only on carrier 1247, which the directed rows do not reach
  row_t directed_rows [] = '{
    '{16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh7FFF, 16'sh7FFF, 1, 16'sh7FFF, 16'sh7FFF, 1'b0},
    '{16'sh8000, 16'sh8000, 1, 16'sh8000, 16'sh8000, 1'b0},
    '{16'sh7FFF, 16'sh8000, 1, 16'sh7FFF, 16'sh8000, 1'b0},
    '{16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF, 1'b0},
    '{16'shFFFF, 16'sh0001, 1, 16'shFFFF, 16'sh0001, 1'b0},
    '{16'sh5555, 16'shAAAA, 1, 16'sh5555, 16'shAAAA, 1'b0},
    '{16'shAAAA, 16'sh5555, 1, 16'shAAAA, 16'sh5555, 1'b0},
    '{16'sh1234, 16'shEDCB, 0, 16'sh0000, 16'sh0000, 1'b0},
    '{16'sh0001, 16'shFFFF, 0, 16'sh0000, 16'sh0000, 1'b0}
  };

  initial begin
    carrier_out_t e;
    reset_setting();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Default setting: all lines zero-length; the clearing pass after reset runs first
    foreach (directed_rows[r]) begin
      e = '{directed_rows[r].e_i, directed_rows[r].e_q, directed_rows[r].e_last};
      send_carrier(directed_rows[r].s_i, directed_rows[r].s_q, directed_rows[r].typed, e);
    end
    end_burst();
    random_carriers(190);

    // Mode register zero (acts as mode 1), layer B above the limit (counts as empty),
    // an unused length code on B, uncovered segments after layer C. Lines fill up and
    // hand back cleared storage; zero-length lines pass samples straight through.
    write_reg(REG_MODE, 4'd0);
    write_reg(REG_SEGMENTS_A, 4'd1);
    write_reg(REG_SEGMENTS_B, 4'd15);
    write_reg(REG_SEGMENTS_C, 4'd2);
    write_reg(REG_LENGTH_A, 4'd1);
    write_reg(REG_LENGTH_B, 4'd7);
    write_reg(REG_LENGTH_C, 4'd3);
    random_carriers(500);

    // Mode 3, every layer claims 13 segments (excess ignored), longest code
    write_reg(REG_MODE, 4'd3);
    write_reg(REG_SEGMENTS_A, 4'd13);
    write_reg(REG_SEGMENTS_B, 4'd13);
    write_reg(REG_SEGMENTS_C, 4'd13);
    write_reg(REG_LENGTH_A, 4'd3);
    write_reg(REG_LENGTH_B, 4'd3);
    write_reg(REG_LENGTH_C, 4'd3);
    random_carriers(300);

    // Mode 2, three layers with different codes; the tail runs without idling
    write_reg(REG_MODE, 4'd2);
    write_reg(REG_SEGMENTS_A, 4'd5);
    write_reg(REG_SEGMENTS_B, 4'd4);
    write_reg(REG_SEGMENTS_C, 4'd4);
    write_reg(REG_LENGTH_A, 4'd2);
    write_reg(REG_LENGTH_B, 4'd1);
    write_reg(REG_LENGTH_C, 4'd0);
    random_carriers(250);
    quiet = 1'b1;
    random_carriers(150);

    wait (pending_carriers.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending_carriers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/tdi_pkg.sv
design/tdi_ctrl.sv
design/tdi_front.sv
design/tdi_line_mem.sv
design/tdi_out_buf.sv
design/isdbt_time_deinterleaver.sv
verif/tb_isdbt_time_deinterleaver.sv
